### hdl/sccs_pkg.sv
// Shared types and constants of the shadow cascade cache scheduler.
package sccs_pkg;

	localparam int unsigned CASCADES_DEF = 4;
	localparam int unsigned MATRIX_WORDS = 8;
	localparam int unsigned WORD_BITS    = 3;
	localparam int unsigned MASK_W       = 4;
	localparam int unsigned CNT_W        = 3;
	localparam int unsigned IN_DATA_W    = 248;
	localparam int unsigned OUT_DATA_W   = 24;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_SCHED = 2'd1,
		MODE_MARK  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SWEEP,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic load_write;
		logic sweep_start;
		logic sweep;
		logic commit_meta;
		logic clear;
		logic emit;
		logic err;
		logic sched_ok;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  owner_nil;
		logic  mark_bad;
		logic  sweep_last;
		logic  out_free;
	} sts_t;

endpackage

### hdl/sccs_ctrl.sv
// Controller state machine of the shadow cascade cache scheduler.
module sccs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  sccs_pkg::sts_t  sts,
	output sccs_pkg::cmd_t  cmd
);

	sccs_pkg::state_t state_q, state_d;
	logic err_q, err_d;
	logic sched_q, sched_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sccs_pkg::ST_IDLE;
			err_q   <= 1'b0;
			sched_q <= 1'b0;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
			sched_q <= sched_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		err_d    = err_q;
		sched_d  = sched_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			sccs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = sccs_pkg::ST_DECODE;
				end
			end
			sccs_pkg::ST_DECODE: begin
				err_d   = 1'b0;
				sched_d = 1'b0;
				state_d = sccs_pkg::ST_FINISH;
				unique case (sts.mode)
					sccs_pkg::MODE_LOAD: cmd.load_write = 1'b1;
					sccs_pkg::MODE_SCHED: begin
						if (sts.owner_nil) begin
							err_d = 1'b1;
						end else begin
							sched_d         = 1'b1;
							cmd.sweep_start = 1'b1;
							state_d         = sccs_pkg::ST_SWEEP;
						end
					end
					sccs_pkg::MODE_MARK: begin
						if (sts.mark_bad) begin
							err_d = 1'b1;
						end else begin
							cmd.commit_meta = 1'b1;
							cmd.sweep_start = 1'b1;
							state_d         = sccs_pkg::ST_SWEEP;
						end
					end
					sccs_pkg::MODE_CLEAR: cmd.clear = 1'b1;
					default: ;
				endcase
			end
			sccs_pkg::ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) state_d = sccs_pkg::ST_DRAIN;
			end
			sccs_pkg::ST_DRAIN: state_d = sccs_pkg::ST_FINISH;
			sccs_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.err      = err_q;
					cmd.sched_ok = sched_q;
					state_d      = sccs_pkg::ST_IDLE;
				end
			end
			default: state_d = sccs_pkg::ST_IDLE;
		endcase
	end

endmodule

### hdl/sccs_dp.sv
// Datapath of the shadow cascade cache scheduler: slot state, matrix memories, result register.
module sccs_dp #(
	parameter int unsigned CASCADES = sccs_pkg::CASCADES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [1:0]                          in_user,
	input  logic [sccs_pkg::IN_DATA_W-1:0]      in_data,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic                                out_user,
	output logic [sccs_pkg::OUT_DATA_W-1:0]     out_data,
	input  sccs_pkg::cmd_t                      cmd,
	output sccs_pkg::sts_t                      sts
);

	localparam int unsigned DEPTH = CASCADES * sccs_pkg::MATRIX_WORDS;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned BANK_SPAN = 1 << AW;
	localparam int unsigned CIW   = (CASCADES > 1) ? $clog2(CASCADES) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	// Captured item.
	logic [1:0]  mode_q;
	logic [1:0]  casc_q;
	logic [2:0]  word_q;
	logic [63:0] mword_q;
	logic [63:0] owner_q;
	logic [31:0] lrev_q, crev_q, prev_q;
	logic [7:0]  budget_q;
	logic [3:0]  rendered_q;

	// Slot and pending state.
	logic [CASCADES-1:0] slot_valid_q;
	logic [63:0] slot_owner_q [CASCADES];
	logic [31:0] slot_lrev_q  [CASCADES];
	logic [31:0] slot_crev_q  [CASCADES];
	logic [31:0] slot_prev_q  [CASCADES];
	logic        bank_sel_q;
	logic        pend_valid_q;
	logic [63:0] pend_owner_q;
	logic [31:0] pend_lrev_q, pend_crev_q, pend_prev_q;
	logic [3:0]  pend_mask_q;

	// Each bank spans a power-of-two window so the bank bit can sit on top of the address.
	logic [63:0] bank_mem [2*BANK_SPAN];
	logic [63:0] slot_mem [DEPTH];

	logic [AW-1:0]       addr_q;
	logic [AW-1:0]       addr_s1;
	logic                rd_s1;
	logic [63:0]         bank_rd_s1;
	logic [63:0]         slot_rd_s1;
	logic [CASCADES-1:0] meta_dirty_q;
	logic [CASCADES-1:0] word_diff_q;

	logic                out_valid_q;
	logic                out_err_q;
	logic [sccs_pkg::OUT_DATA_W-1:0] out_data_q;

	logic [CIW-1:0] casc_s1;
	logic           is_sched;
	logic [AW:0]    load_addr;
	logic [AW:0]    rd_addr;
	logic [3:0]     dirty, update, sample;
	logic [2:0]     inval, granted, deferred;

	assign is_sched  = (mode_q == sccs_pkg::MODE_SCHED);
	assign casc_s1   = CIW'(addr_s1 >> sccs_pkg::WORD_BITS);
	assign load_addr = {bank_sel_q, AW'({casc_q, word_q})};
	// Schedule reads the filling bank, commit reads the frozen one.
	assign rd_addr   = {is_sched ? bank_sel_q : ~bank_sel_q, addr_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q     <= in_user;
			casc_q     <= in_data[1:0];
			word_q     <= in_data[4:2];
			mword_q    <= in_data[68:5];
			owner_q    <= in_data[132:69];
			lrev_q     <= in_data[164:133];
			crev_q     <= in_data[196:165];
			prev_q     <= in_data[228:197];
			budget_q   <= in_data[236:229];
			rendered_q <= in_data[240:237];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_write && (32'(casc_q) < CASCADES)) bank_mem[load_addr] <= mword_q;
		bank_rd_s1 <= bank_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (rd_s1 && !is_sched && rendered_q[casc_s1]) slot_mem[addr_s1] <= bank_rd_s1;
		slot_rd_s1 <= slot_mem[addr_q];
		addr_s1    <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			rd_s1        <= 1'b0;
			word_diff_q  <= '0;
			meta_dirty_q <= '0;
		end else begin
			rd_s1 <= cmd.sweep;
			if (cmd.sweep_start) begin
				addr_q      <= '0;
				word_diff_q <= '0;
				for (int i = 0; i < CASCADES; i++) begin
					meta_dirty_q[i] <= !slot_valid_q[i] || slot_owner_q[i] != owner_q ||
						slot_lrev_q[i] != lrev_q || slot_crev_q[i] != crev_q ||
						slot_prev_q[i] != prev_q;
				end
			end else if (cmd.sweep) begin
				addr_q <= addr_q + AW'(1);
			end
			if (rd_s1 && is_sched && (slot_rd_s1 != bank_rd_s1)) word_diff_q[casc_s1] <= 1'b1;
		end
	end

	always_comb begin
		logic [2:0] n;
		n      = '0;
		dirty  = '0;
		update = '0;
		inval  = '0;
		for (int i = 0; i < CASCADES; i++) begin
			dirty[i] = meta_dirty_q[i] | word_diff_q[i];
			inval    = inval + 3'(dirty[i]);
			if (dirty[i] && ({5'd0, n} < budget_q)) begin
				update[i] = 1'b1;
				n         = n + 3'd1;
			end
		end
		granted  = n;
		deferred = inval - granted;
		sample   = (~dirty | update) & 4'(((1 << CASCADES) - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			bank_sel_q   <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_owner_q <= '0;
			pend_lrev_q  <= '0;
			pend_crev_q  <= '0;
			pend_prev_q  <= '0;
			pend_mask_q  <= '0;
		end else if (cmd.clear || cmd.commit_meta) begin
			if (cmd.clear) slot_valid_q <= '0;
			for (int i = 0; i < CASCADES; i++) begin
				if (cmd.commit_meta && rendered_q[i]) slot_valid_q[i] <= 1'b1;
			end
			pend_valid_q <= 1'b0;
			pend_owner_q <= '0;
			pend_lrev_q  <= '0;
			pend_crev_q  <= '0;
			pend_prev_q  <= '0;
			pend_mask_q  <= '0;
		end else if (cmd.emit && cmd.sched_ok) begin
			pend_valid_q <= 1'b1;
			pend_owner_q <= owner_q;
			pend_lrev_q  <= lrev_q;
			pend_crev_q  <= crev_q;
			pend_prev_q  <= prev_q;
			pend_mask_q  <= update;
			bank_sel_q   <= ~bank_sel_q;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CASCADES; i++) begin
			if (cmd.commit_meta && rendered_q[i]) begin
				slot_owner_q[i] <= pend_owner_q;
				slot_lrev_q[i]  <= pend_lrev_q;
				slot_crev_q[i]  <= pend_crev_q;
				slot_prev_q[i]  <= pend_prev_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_err_q  <= cmd.err;
			out_data_q <= '0;
			if (cmd.sched_ok) begin
				out_data_q <= {3'd0, deferred, 3'(CASCADES) - inval, inval, sample, update, dirty};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_user  = out_err_q;
	assign out_data  = out_data_q;

	assign sts.mode       = sccs_pkg::mode_t'(mode_q);
	assign sts.owner_nil  = (owner_q == '0);
	assign sts.mark_bad   = !pend_valid_q || ((rendered_q & ~pend_mask_q) != '0);
	assign sts.sweep_last = (addr_q == LAST_ADDR);
	assign sts.out_free   = !out_valid_q || out_ready;

`ifndef SYNTHESIS
	a_update_in_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_data_q[7:4] & ~out_data_q[3:0]) == 4'd0))
		else $error("update mask grants a clean cascade");
	a_pending_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!pend_valid_q |-> (pend_mask_q == 4'd0))
		else $error("pending update mask without a pending request");
	a_sched_flips_bank: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.sched_ok) |=> (bank_sel_q != $past(bank_sel_q)))
		else $error("schedule did not swap the staging bank");
	a_err_no_masks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_err_q) |-> (out_data_q == '0))
		else $error("error result carries masks");
`endif

endmodule

### hdl/shadow_cascade_cache_scheduler_unit.sv
// Shadow cascade cache scheduler: load, schedule, commit of cached cascades.
// One item is taken at a time. A load, a mark-rendered that fails, a nil-owner
// schedule and a reset item go from decode straight to finish without a sweep:
// the result is registered at finish and the next input transfer can follow it.
// A schedule sweeps all CASCADES*8 stored matrix words through the single read
// port of each matrix memory, one word a cycle, and its result is emitted after
// the sweep drains; a successful mark-rendered copies the words of the rendered
// cascades from the frozen staging bank into the slot memory over the same sweep.
// A finished result sits in an output register and the next item may be
// taken while it waits; a second result stalls until the first is transferred.
module shadow_cascade_cache_scheduler_unit #(
	parameter int unsigned CASCADES = sccs_pkg::CASCADES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// cascade_index, word_index, matrix_word, owner, light_revision,
	// caster_revision, pipeline_revision, max_updates, rendered_mask
	input  logic [sccs_pkg::IN_DATA_W-1:0]   s_tdata,
	// mode
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// dirty_mask, update_mask, sampleable_mask, invalidated_count,
	// hit_count, deferred_count
	output logic [sccs_pkg::OUT_DATA_W-1:0]  m_tdata,
	// error
	output logic                             m_tuser
);

	sccs_pkg::cmd_t cmd;
	sccs_pkg::sts_t sts;

	sccs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sccs_dp #(.CASCADES(CASCADES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_user   (s_tuser),
		.in_data   (s_tdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_user  (m_tuser),
		.out_data  (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

### bench/shadow_cascade_cache_scheduler_unit_chk.sv
// Checker for the shadow cascade cache scheduler: predicts results and compares them.
module shadow_cascade_cache_scheduler_unit_chk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [sccs_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]                      s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [sccs_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            m_tuser,
	output int                              fail_count,
	output int                              waiting,
	output int                              result_count
);

	// Packed from the highest bit down, so dirty lands in the lowest bits as on m_tdata.
	typedef struct packed {
		logic       error;
		logic [2:0] deferred;
		logic [2:0] hits;
		logic [2:0] inval;
		logic [3:0] sample;
		logic [3:0] update;
		logic [3:0] dirty;
	} verdict_t;

	logic        slot_ok [4];
	logic [63:0] slot_own [4];
	logic [31:0] slot_rev [4][3];
	logic [63:0] slot_mat [4][8];
	logic [63:0] stage [2][4][8];
	logic        bank;
	logic        pend_ok;
	logic [63:0] pend_own;
	logic [31:0] pend_rev [3];
	logic [3:0]  pend_upd;
	verdict_t    expected_mem [16];
	int          wr_idx = 0;
	int          rd_idx = 0;

	function automatic logic [2:0] ones(logic [3:0] v);
		return 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
	endfunction

	task automatic model_reset();
		fail_count = 0;
		result_count = 0;
		wr_idx = 0;
		rd_idx = 0;
		bank = 0;
		pend_ok = 0;
		pend_own = 0;
		pend_rev = '{0, 0, 0};
		pend_upd = 0;
		for (int i = 0; i < 4; i++) begin
			slot_ok[i] = 0;
			slot_own[i] = 0;
			slot_rev[i] = '{0, 0, 0};
			for (int w = 0; w < 8; w++) begin
				slot_mat[i][w] = 0;
				stage[0][i][w] = 0;
				stage[1][i][w] = 0;
			end
		end
	endtask

	task automatic predict_item(logic [1:0] mode, logic [sccs_pkg::IN_DATA_W-1:0] d);
		verdict_t r;
		logic [1:0] ci;
		logic [2:0] wi;
		logic [63:0] own;
		logic [31:0] rv [3];
		logic [7:0] budget;
		logic [3:0] rmask;
		logic dflag;
		r = '0;
		ci = d[1:0];
		wi = d[4:2];
		own = d[132:69];
		rv[0] = d[164:133];
		rv[1] = d[196:165];
		rv[2] = d[228:197];
		budget = d[236:229];
		rmask = d[240:237];
		case (sccs_pkg::mode_t'(mode))
			sccs_pkg::MODE_LOAD: stage[bank][ci][wi] = d[68:5];
			sccs_pkg::MODE_SCHED: begin
				if (own == 0) begin
					r.error = 1;
				end else begin
					for (int i = 0; i < 4; i++) begin
						dflag = !slot_ok[i] || slot_own[i] != own || slot_rev[i][0] != rv[0]
							|| slot_rev[i][1] != rv[1] || slot_rev[i][2] != rv[2];
						for (int w = 0; w < 8; w++)
							if (slot_mat[i][w] != stage[bank][i][w]) dflag = 1;
						if (dflag) r.dirty[i] = 1;
						else r.sample[i] = 1;
					end
					for (int i = 0; i < 4; i++)
						if (r.dirty[i] && budget != 0) begin
							r.update[i] = 1;
							budget--;
						end
					r.sample |= r.update;
					r.inval = ones(r.dirty);
					r.hits = 3'd4 - r.inval;
					r.deferred = ones(r.dirty & ~r.update);
					pend_ok = 1;
					pend_own = own;
					pend_rev = rv;
					pend_upd = r.update;
					bank = ~bank;
				end
			end
			sccs_pkg::MODE_MARK: begin
				if (!pend_ok || (rmask & ~pend_upd) != 0) begin
					r.error = 1;
				end else begin
					for (int i = 0; i < 4; i++)
						if (rmask[i]) begin
							slot_own[i] = pend_own;
							slot_rev[i] = pend_rev;
							slot_mat[i] = stage[~bank][i];
							slot_ok[i] = 1;
						end
					pend_ok = 0;
					pend_upd = 0;
				end
			end
			default: begin
				for (int i = 0; i < 4; i++) slot_ok[i] = 0;
				pend_ok = 0;
				pend_upd = 0;
			end
		endcase
		expected_mem[wr_idx % 16] = r;
		wr_idx++;
	endtask

	assign waiting = wr_idx - rd_idx;

	always @(posedge clk) begin
		verdict_t got, exp_r;
		if (!arst_n) begin
			model_reset();
		end else begin
			if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[20:0]};
				result_count++;
				if (wr_idx == rd_idx) begin
					$display("%0t: unexpected result %h", $time, got);
					fail_count++;
				end else begin
					exp_r = expected_mem[rd_idx % 16];
					rd_idx++;
					if (got !== exp_r || m_tdata[23:21] !== 3'b000) begin
						$display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

### bench/shadow_cascade_cache_scheduler_unit_tb.sv
// Testbench top for the shadow cascade cache scheduler: stimulus and verdict.
module shadow_cascade_cache_scheduler_unit_tb;

	logic                             clk = 0;
	logic                             arst_n = 0;
	logic                             s_tvalid = 0;
	logic                             s_tready;
	logic [sccs_pkg::IN_DATA_W-1:0]   s_tdata = '0;
	logic [1:0]                       s_tuser = sccs_pkg::MODE_LOAD;
	logic                             m_tvalid;
	logic                             m_tready = 0;
	logic [sccs_pkg::OUT_DATA_W-1:0]  m_tdata;
	logic                             m_tuser;
	int                               fail_count, waiting, result_count;
	int                               send_idle, recv_idle;
	int                               item_count;
	logic [63:0]                      cur_owner;
	logic [31:0]                      cur_rev [3];
	logic [63:0]                      cur_mat [4][8];

	always #4 clk = ~clk;

	shadow_cascade_cache_scheduler_unit i_dut (.*);

	shadow_cascade_cache_scheduler_unit_chk i_chk (.*);

	always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

	task automatic send_item(sccs_pkg::mode_t mode, logic [sccs_pkg::IN_DATA_W-1:0] d);
		while ($urandom_range(99) < send_idle) @(negedge clk);
		s_tvalid = 1;
		s_tuser = mode;
		s_tdata = d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		s_tvalid = 0;
		item_count++;
	endtask

	function automatic logic [sccs_pkg::IN_DATA_W-1:0] pack_item(logic [1:0] ci,
			logic [2:0] wi, logic [63:0] mw, logic [63:0] own, logic [31:0] lr,
			logic [31:0] cr, logic [31:0] pr, logic [7:0] budget, logic [3:0] rmask);
		logic [sccs_pkg::IN_DATA_W-1:0] d;
		d = '0;
		d[240:0] = {rmask, budget, pr, cr, lr, own, mw, wi, ci};
		return d;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic load(logic [1:0] ci, logic [2:0] wi, logic [63:0] mw);
		send_item(sccs_pkg::MODE_LOAD, pack_item(ci, wi, mw, rand64(), $urandom, $urandom,
			$urandom, 8'($urandom), 4'($urandom)));
	endtask

	// Loads every staging word so a later schedule never reads an unwritten one.
	task automatic load_all();
		for (int c = 0; c < 4; c++)
			for (int w = 0; w < 8; w++) load(2'(c), 3'(w), cur_mat[c][w]);
	endtask

	task automatic schedule(logic [63:0] own, logic [7:0] budget);
		send_item(sccs_pkg::MODE_SCHED, pack_item(2'($urandom), 3'($urandom), rand64(), own,
			cur_rev[0], cur_rev[1], cur_rev[2], budget, 4'($urandom)));
	endtask

	task automatic mark(logic [3:0] rmask);
		send_item(sccs_pkg::MODE_MARK, pack_item(2'($urandom), 3'($urandom), rand64(),
			rand64(), $urandom, $urandom, $urandom, 8'($urandom), rmask));
	endtask

	task automatic clear_item();
		send_item(sccs_pkg::MODE_CLEAR, pack_item(2'($urandom), 3'($urandom), rand64(),
			rand64(), $urandom, $urandom, $urandom, 8'($urandom), 4'($urandom)));
	endtask

	// One frame: perturb the request a little, reload, schedule, then mostly commit, sometimes clear or do neither.
	task automatic random_frame();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) cur_owner = rand64();
		else if (pick == 1) cur_rev[$urandom_range(2)] = $urandom;
		else if (pick < 4) cur_mat[$urandom_range(3)][$urandom_range(7)] = rand64();
		load_all();
		schedule($urandom_range(9) == 0 ? 64'd0 : cur_owner,
			$urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(4)));
		case ($urandom_range(9))
			0: mark(4'($urandom));
			1: clear_item();
			2: ;
			default: mark(4'($urandom) & 4'($urandom_range(15)) & {4{1'b1}});
		endcase
	endtask

	initial begin
		#200000000;
		$display("shadow_cascade_cache_scheduler_unit regression: fail");
		$finish;
	end

	initial begin
		item_count = 0;
		send_idle = 0;
		recv_idle = 0;
		cur_owner = 64'hFFFF_FFFF_FFFF_FFFF;
		cur_rev = '{32'hFFFF_FFFF, 32'h0, 32'h8000_0001};
		for (int c = 0; c < 4; c++)
			for (int w = 0; w < 8; w++) cur_mat[c][w] = rand64();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: errors first, then the usual frame and the special cases.
		mark(4'h0);
		schedule(64'd0, 8'd4);
		load(2'd3, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
		load(2'd0, 3'd0, 64'h0);
		load_all();
		schedule(cur_owner, 8'd0);
		mark(4'h1);
		mark(4'h0);
		load_all();
		schedule(cur_owner, 8'd255);
		schedule(cur_owner, 8'd2);
		mark(4'hF);
		mark(4'h3);
		load_all();
		schedule(cur_owner, 8'd4);
		mark(4'hF);
		load_all();
		schedule(cur_owner, 8'd4);
		clear_item();
		mark(4'h0);
		load_all();
		schedule(64'd1, 8'd1);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = phase == 0 ? 7 : phase == 1 ? 46 : 0;
			recv_idle = phase == 0 ? 46 : phase == 1 ? 7 : 0;
			while (item_count < 600 * (phase + 1)) begin
				if ($urandom_range(19) == 0) load(2'($urandom), 3'($urandom), rand64());
				random_frame();
			end
			while (waiting != 0) @(negedge clk);
		end
		repeat (60) @(negedge clk);
		$display("Ran %0d items through load, schedule, commit and clear, %0d results checked.",
			item_count, result_count);
		if (fail_count == 0 && waiting == 0)
			$display("shadow_cascade_cache_scheduler_unit regression: pass");
		else
			$display("shadow_cascade_cache_scheduler_unit regression: fail");
		$finish;
	end
endmodule

### filelist.f
hdl/sccs_pkg.sv
hdl/sccs_ctrl.sv
hdl/sccs_dp.sv
hdl/shadow_cascade_cache_scheduler_unit.sv
bench/shadow_cascade_cache_scheduler_unit_chk.sv
bench/shadow_cascade_cache_scheduler_unit_tb.sv
